// ----- hw/rtl/rtdf_pkg.sv -----
package rtdf_pkg;

   localparam int unsigned FULL_SCALE_DEF = 4095;

   localparam int unsigned ADC_W      = 12;
   localparam int unsigned ALPHA_W    = 15;
   localparam int unsigned DIVIDE_W   = 16;
   localparam int unsigned RES_W      = 24;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned TEMP_W     = 32;
   localparam int unsigned COUNTS_W   = 12;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam int unsigned Q_BITS   = 15;
   localparam int unsigned Q_HALF   = 16384;
   localparam int unsigned MILLI    = 1000;
   localparam int unsigned MILLI_W  = 10;
   localparam int unsigned OPB_W    = 16;
   localparam int unsigned CLAMP_W  = 17;

   localparam logic [ALPHA_W-1:0]  ALPHA_RST   = 15'd1937;
   localparam logic [DIVIDE_W-1:0] DIVIDE_RST  = 16'd50;
   localparam logic [RES_W-1:0]    BOTTOM_RST  = 24'd1651376;
   localparam logic [RES_W-1:0]    NOMINAL_RST = 24'd1000000;
   localparam logic [COEF_W-1:0]   COEF_RST    = 16'd3850;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_FILTER_ALPHA       = 3'd0,
      CFG_OUTPUT_DIVIDE      = 3'd1,
      CFG_BOTTOM_RESISTANCE  = 3'd2,
      CFG_NOMINAL_RESISTANCE = 3'd3,
      CFG_TEMP_COEFFICIENT   = 3'd4
   } cfg_index_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]  filter_alpha;
      logic [DIVIDE_W-1:0] output_divide;
      logic [RES_W-1:0]    bottom_resistance;
      logic [RES_W-1:0]    nominal_resistance;
      logic [COEF_W-1:0]   temp_coefficient;
   } cfg_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctrl_type;

endpackage

// ----- hw/rtl/rtdf_csr.sv -----
module rtdf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rtdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rtdf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rtdf_pkg::cfg_type                 cfg
);
   import rtdf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (cfg_index_type'(csr_index))
            CFG_FILTER_ALPHA:       cfg_in.filter_alpha       = csr_wdata[ALPHA_W-1:0];
            CFG_OUTPUT_DIVIDE:      cfg_in.output_divide      = csr_wdata[DIVIDE_W-1:0];
            CFG_BOTTOM_RESISTANCE:  cfg_in.bottom_resistance  = csr_wdata[RES_W-1:0];
            CFG_NOMINAL_RESISTANCE: cfg_in.nominal_resistance = csr_wdata[RES_W-1:0];
            CFG_TEMP_COEFFICIENT:   cfg_in.temp_coefficient   = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha       <= ALPHA_RST;
         cfg_ff.output_divide      <= DIVIDE_RST;
         cfg_ff.bottom_resistance  <= BOTTOM_RST;
         cfg_ff.nominal_resistance <= NOMINAL_RST;
         cfg_ff.temp_coefficient   <= COEF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/rtdf_iter_unit.sv -----
module rtdf_iter_unit #(
   parameter int unsigned DATA_W = 47
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rtdf_pkg::unit_ctrl_type         ctrl,
   input  logic [$clog2(DATA_W+1)-1:0]     steps,
   input  logic [DATA_W-1:0]               opa,
   input  logic [rtdf_pkg::OPB_W-1:0]      opb,
   output logic [DATA_W-1:0]               result,
   output logic                            done
);
   import rtdf_pkg::*;

   localparam int unsigned STEP_W = $clog2(DATA_W+1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic [OPB_W:0]    rem_ff, rem_in;
   logic [OPB_W:0]    rem_shift;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      opb_in    = opb_ff;
      rem_in    = rem_ff;
      rem_shift = {rem_ff[OPB_W-1:0], acc_ff[DATA_W-1]};
      if (ctrl.start) begin
         busy_in  = 1'b1;
         op_in    = ctrl.op;
         count_in = steps;
         opb_in   = opb;
         rem_in   = '0;
         if (ctrl.op == OP_MUL) begin
            acc_in   = '0;
            mcand_in = opa;
         end else begin
            acc_in = opa;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in = {mcand_ff[DATA_W-2:0], 1'b0};
               opb_in   = {1'b0, opb_ff[OPB_W-1:1]};
            end
            OP_DIV: begin
               if (rem_shift >= {1'b0, opb_ff}) begin
                  rem_in = rem_shift - {1'b0, opb_ff};
                  acc_in = {acc_ff[DATA_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_shift;
                  acc_in = {acc_ff[DATA_W-2:0], 1'b0};
               end
            end
            default: ;
         endcase
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      opb_ff   <= opb_in;
      rem_ff   <= rem_in;
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

// ----- hw/rtl/rtd_adc_filter_temperature.sv -----
// Channel  Direction  Transaction contents
// req_     in         req_tdata: adc_sample [11:0], zero pad [15:12]
// rsp_     out        rsp_tdata: temperature_milli [31:0], filtered_counts [43:32];
//                     rsp_tuser: clipped
// csr_     in         one register write per cycle when csr_wen is high
//
// A sample without a result runs the filter multiply on the shared multiply/divide
// unit, one bit per cycle; the first sample after reset only seeds the filter.
// A sample that ends a result period adds a conversion, dominated by the two
// bit-serial divisions, whose width grows with CW = clog2(FULL_SCALE).
// req_tready is high only between samples. A result waits in the output register;
// handing the next result to that register stalls only while it is still full.
// Reset is synchronous and clears the filter, the sample counter and the output.
module rtd_adc_filter_temperature #(
   parameter int unsigned FULL_SCALE = rtdf_pkg::FULL_SCALE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // adc_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,   // temperature_milli, filtered_counts
   output logic                              rsp_tuser,   // clipped
   input  logic                              csr_wen,
   input  logic [rtdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rtdf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtdf_pkg::*;

   localparam int unsigned CW     = $clog2(FULL_SCALE);
   localparam int unsigned SW     = CW + Q_BITS;
   localparam int unsigned RW     = CW + RES_W + 1;
   localparam int unsigned NW     = RW + MILLI_W;
   localparam int unsigned STEP_W = $clog2(NW + 1);
   localparam logic [CLAMP_W-1:0] FS_X = CLAMP_W'(FULL_SCALE);

   typedef enum logic [3:0] {
      S_IDLE, S_FILT, S_FWAIT, S_FADD, S_TICK, S_ROUND, S_CLAMP, S_RMUL,
      S_RMWAIT, S_RDWAIT, S_TMUL, S_TMWAIT, S_TDWAIT, S_EMIT
   } state_type;

   function automatic logic [CLAMP_W-1:0] clamp_fs(input logic [CLAMP_W-1:0] v);
      logic [CLAMP_W-1:0] r;
      if (v == '0) begin
         r = CLAMP_W'(1);
      end else if (v >= FS_X) begin
         r = FS_X - CLAMP_W'(1);
      end else begin
         r = v;
      end
      return r;
   endfunction

   cfg_type cfg;

   rtdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   unit_ctrl_type     unit_ctrl;
   logic [STEP_W-1:0] unit_steps;
   logic [NW-1:0]     unit_opa;
   logic [OPB_W-1:0]  unit_opb;
   logic [NW-1:0]     unit_result;
   logic              unit_done;

   rtdf_iter_unit #(.DATA_W(NW)) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (unit_ctrl),
      .steps  (unit_steps),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .result (unit_result),
      .done   (unit_done)
   );

   state_type            state_ff, state_in;
   logic                 primed_ff, primed_in;
   logic [DIVIDE_W-1:0]  tick_ff, tick_in;
   logic [SW-1:0]        smooth_ff, smooth_in;
   logic [CW-1:0]        sample_ff, sample_in;
   logic                 neg_ff, neg_in;
   logic signed [NW:0]   prod_ff, prod_in;
   logic [CW-1:0]        counts_ff, counts_in;
   logic [CW-1:0]        a_ff, a_in;
   logic signed [RW:0]   diff_ff, diff_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0]    rsp_temp_ff, rsp_temp_in;
   logic [CW-1:0]        rsp_counts_ff, rsp_counts_in;
   logic                 rsp_clip_ff, rsp_clip_in;
   logic [TEMP_W-1:0]    temp_ff, temp_in;
   logic                 clip_ff, clip_in;

   logic [SW-1:0]        sq;
   logic signed [SW:0]   filt_diff;
   logic [SW-1:0]        filt_mag;
   logic signed [NW:0]   p_shift;
   logic [SW:0]          smooth_sum;
   logic [SW:0]          round_sum;
   logic [DIVIDE_W-1:0]  tick_next;
   logic [CLAMP_W-1:0]   fs_minus_a;
   logic [RW-1:0]        diff_mag;
   logic [CW+COUNTS_W-1:0] counts_ext;

   always_comb begin
      sq         = {sample_ff, Q_BITS'(0)};
      filt_diff  = $signed({1'b0, sq}) - $signed({1'b0, smooth_ff});
      filt_mag   = filt_diff[SW] ? SW'(-filt_diff) : filt_diff[SW-1:0];
      p_shift    = prod_ff >>> Q_BITS;
      smooth_sum = {1'b0, smooth_ff} + p_shift[SW:0];
      round_sum  = {1'b0, smooth_ff} + (SW+1)'(Q_HALF);
      tick_next  = tick_ff + DIVIDE_W'(1);
      fs_minus_a = FS_X - CLAMP_W'(a_ff);
      diff_mag   = diff_ff[RW] ? RW'(-diff_ff) : diff_ff[RW-1:0];
      counts_ext = {{COUNTS_W{1'b0}}, rsp_counts_ff};
   end

   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      tick_in       = tick_ff;
      smooth_in     = smooth_ff;
      sample_in     = sample_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      counts_in     = counts_ff;
      a_in          = a_ff;
      diff_in       = diff_ff;
      zero_in       = zero_ff;
      temp_in       = temp_ff;
      clip_in       = clip_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_counts_in = rsp_counts_ff;
      rsp_clip_in   = rsp_clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unit_ctrl     = '{start: 1'b0, op: OP_MUL};
      unit_steps    = '0;
      unit_opa      = '0;
      unit_opb      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = CW'(clamp_fs(CLAMP_W'(req_tdata[ADC_W-1:0])));
               state_in  = S_FILT;
            end
         end
         S_FILT: begin
            if (!primed_ff) begin
               smooth_in = sq;
               primed_in = 1'b1;
               state_in  = S_TICK;
            end else begin
               neg_in     = filt_diff[SW];
               unit_ctrl  = '{start: 1'b1, op: OP_MUL};
               unit_steps = STEP_W'(ALPHA_W);
               unit_opa   = NW'(filt_mag);
               unit_opb   = OPB_W'(cfg.filter_alpha);
               state_in   = S_FWAIT;
            end
         end
         S_FWAIT: begin
            if (unit_done) begin
               prod_in  = neg_ff ? -$signed({1'b0, unit_result})
                                 : $signed({1'b0, unit_result});
               state_in = S_FADD;
            end
         end
         S_FADD: begin
            smooth_in = smooth_sum[SW-1:0];
            state_in  = S_TICK;
         end
         S_TICK: begin
            if (tick_next >= cfg.output_divide) begin
               tick_in  = '0;
               state_in = S_ROUND;
            end else begin
               tick_in  = tick_next;
               state_in = S_IDLE;
            end
         end
         S_ROUND: begin
            counts_in = round_sum[Q_BITS +: CW];
            state_in  = S_CLAMP;
         end
         S_CLAMP: begin
            a_in     = CW'(clamp_fs(CLAMP_W'(counts_ff)));
            state_in = S_RMUL;
         end
         S_RMUL: begin
            unit_ctrl  = '{start: 1'b1, op: OP_MUL};
            unit_steps = STEP_W'(OPB_W);
            unit_opa   = NW'(cfg.bottom_resistance);
            unit_opb   = fs_minus_a[OPB_W-1:0];
            state_in   = S_RMWAIT;
         end
         S_RMWAIT: begin
            if (unit_done) begin
               unit_ctrl  = '{start: 1'b1, op: OP_DIV};
               unit_steps = STEP_W'(NW);
               unit_opa   = unit_result + NW'(a_ff >> 1);
               unit_opb   = OPB_W'(a_ff);
               state_in   = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            if (unit_done) begin
               diff_in  = $signed({1'b0, unit_result[RW-1:0]})
                        - $signed({1'b0, RW'(cfg.nominal_resistance)});
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            neg_in     = diff_ff[RW];
            unit_ctrl  = '{start: 1'b1, op: OP_MUL};
            unit_steps = STEP_W'(MILLI_W);
            unit_opa   = NW'(diff_mag);
            unit_opb   = OPB_W'(MILLI);
            state_in   = S_TMWAIT;
         end
         S_TMWAIT: begin
            if (unit_done) begin
               zero_in    = (unit_result == '0);
               unit_ctrl  = '{start: 1'b1, op: OP_DIV};
               unit_steps = STEP_W'(NW);
               unit_opa   = unit_result;
               unit_opb   = cfg.temp_coefficient;
               state_in   = S_TDWAIT;
            end
         end
         S_TDWAIT: begin
            if (unit_done) begin
               if (zero_ff) begin
                  temp_in = '0;
                  clip_in = 1'b0;
               end else if (!neg_ff) begin
                  if (unit_result > NW'(33'h0_7FFF_FFFF)) begin
                     temp_in = 32'h7FFF_FFFF;
                     clip_in = 1'b1;
                  end else begin
                     temp_in = unit_result[TEMP_W-1:0];
                     clip_in = 1'b0;
                  end
               end else begin
                  if (unit_result > NW'(33'h0_8000_0000)) begin
                     temp_in = 32'h8000_0000;
                     clip_in = 1'b1;
                  end else begin
                     temp_in = -unit_result[TEMP_W-1:0];
                     clip_in = 1'b0;
                  end
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_in   = temp_ff;
               rsp_counts_in = counts_ff;
               rsp_clip_in   = clip_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         tick_ff      <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         tick_ff      <= tick_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      counts_ff     <= counts_in;
      a_ff          <= a_in;
      diff_ff       <= diff_in;
      zero_ff       <= zero_in;
      temp_ff       <= temp_in;
      clip_ff       <= clip_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_counts_ff <= rsp_counts_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, counts_ext[COUNTS_W-1:0], rsp_temp_ff};
   assign rsp_tuser  = rsp_clip_ff;

endmodule
